>>> rtl/kcu_pkg.sv
// Shared types and constants for the sliding-window kappa unit.
// Used by kcu_cmem, kcu_kappa and sliding_window_cohen_kappa_unit.
`default_nettype none

package kcu_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int MAX_CLASSES  = 16;

  localparam int LBL_W      = 4;
  localparam int CNT_W      = 11;
  localparam int SQ_W       = 2 * CNT_W;
  localparam int CC_W       = 5;
  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int Q_FRAC     = 16;
  localparam int QCNT_W     = $clog2(Q_FRAC + 1);
  localparam int KAP_W      = 18;
  localparam int PAIR_W     = 2 * LBL_W;
  localparam int CWORD_W    = 2 * CNT_W;
  localparam int IN_DATA_W  = 8;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT = 1'd1;

  localparam logic [CNT_W-1:0] WS_RESET = 11'd50;
  localparam logic [CC_W-1:0]  CC_RESET = 5'd2;

  localparam logic signed [KAP_W-1:0] Q_ONE = 18'sd65536;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_RD,
    S_MOD,
    S_KSTART,
    S_KWAIT,
    S_OUT
  } kcu_state_t;

  typedef enum logic [1:0] {
    ST_EV_ACT,
    ST_EV_PRED,
    ST_IN_ACT,
    ST_IN_PRED
  } kcu_step_t;

  typedef enum logic [1:0] {
    K_IDLE,
    K_MUL,
    K_PREP,
    K_DIV
  } kcu_kstate_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] agree;
    logic [SQ_W-1:0]  s;
  } kcu_kreq_t;

  typedef struct packed {
    logic                     done;
    logic signed [KAP_W-1:0]  kappa;
  } kcu_kres_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } kcu_cmem_ctl_t;

endpackage

`default_nettype wire

>>> rtl/kcu_cmem.sv
// Per-class count memory: one word {actual count, predicted count} per class.
// Synchronous read, registered on rd_en; valid bits make unwritten rows read zero.
// Depends on kcu_pkg.
`default_nettype none

module kcu_cmem
  import kcu_pkg::*;
#(
  parameter int NUM_CLASSES = 16,
  localparam int CA_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  kcu_cmem_ctl_t       ctl,
  input  wire  [CA_W-1:0]     rd_addr,
  input  wire  [CA_W-1:0]     wr_addr,
  input  wire  [CWORD_W-1:0]  wr_data,
  output logic [CWORD_W-1:0]  rd_data
);

  logic [CWORD_W-1:0]     mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] vld_r;
  logic [CWORD_W-1:0]     mem_q_r;
  logic                   vld_q_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (ctl.rd_en) begin
        vld_q_r <= vld_r[rd_addr];
      end
      if (ctl.wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = vld_q_r ? mem_q_r : '0;

endmodule

`default_nettype wire

>>> rtl/kcu_kappa.sv
// Kappa evaluation: squares the window length, forms numerator and denominator,
// then, unless kappa saturates, runs a restoring division one quotient bit per cycle. Depends on kcu_pkg.
`default_nettype none

module kcu_kappa
  import kcu_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  kcu_kreq_t  req,
  output kcu_kres_t  res
);

  localparam int DW = SQ_W + Q_FRAC;

  kcu_kstate_t              kst_r, kst_nxt;
  logic [CNT_W-1:0]         n_r, ag_r;
  logic [SQ_W-1:0]          s_r, nn_r, pos_r, den_r, rem_r;
  logic [Q_FRAC:0]          dsh_r, q_r;
  logic [QCNT_W-1:0]        cnt_r;
  logic                     neg_r, done_r;
  logic signed [KAP_W-1:0]  kappa_r;

  logic [SQ_W-1:0]          den, mag;
  logic                     neg, sat_one, sat_mag;
  logic [DW-1:0]            dvd;
  logic [SQ_W:0]            r2;
  logic                     ge;
  logic [Q_FRAC:0]          q_nxt;
  logic [KAP_W-1:0]         qx;
  logic                     last_bit;

  always_comb begin
    den     = nn_r - s_r;
    neg     = pos_r < s_r;
    mag     = neg ? (s_r - pos_r) : (pos_r - s_r);
    sat_one = s_r >= nn_r;
    sat_mag = mag >= den;
    dvd     = {mag, {Q_FRAC{1'b0}}} + DW'(den >> 1);
    r2      = {rem_r, dsh_r[Q_FRAC]};
    ge      = r2 >= {1'b0, den_r};
    q_nxt   = {q_r[Q_FRAC-1:0], ge};
    qx      = {1'b0, q_nxt};
    last_bit = cnt_r == QCNT_W'(Q_FRAC);
  end

  always_comb begin
    kst_nxt = kst_r;
    case (kst_r)
      K_IDLE: if (req.start) kst_nxt = K_MUL;
      K_MUL:  kst_nxt = K_PREP;
      K_PREP: kst_nxt = (sat_one || sat_mag) ? K_IDLE : K_DIV;
      K_DIV:  if (last_bit) kst_nxt = K_IDLE;
      default: kst_nxt = K_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kst_r  <= K_IDLE;
      done_r <= 1'b0;
    end else begin
      kst_r  <= kst_nxt;
      done_r <= ((kst_r == K_PREP) && (sat_one || sat_mag)) || ((kst_r == K_DIV) && last_bit);
    end
  end

  always_ff @(posedge clk) begin
    case (kst_r)
      K_IDLE: begin
        if (req.start) begin
          n_r  <= req.n;
          ag_r <= req.agree;
          s_r  <= req.s;
        end
      end
      K_MUL: begin
        nn_r  <= n_r * n_r;
        pos_r <= n_r * ag_r;
      end
      K_PREP: begin
        den_r <= den;
        neg_r <= neg;
        cnt_r <= '0;
        q_r   <= '0;
        rem_r <= SQ_W'(dvd[DW-1:Q_FRAC+1]);
        dsh_r <= dvd[Q_FRAC:0];
        if (sat_one) begin
          kappa_r <= Q_ONE;
        end else if (sat_mag) begin
          kappa_r <= neg ? -Q_ONE : Q_ONE;
        end
      end
      K_DIV: begin
        rem_r <= SQ_W'(ge ? (r2 - {1'b0, den_r}) : r2);
        dsh_r <= {dsh_r[Q_FRAC-1:0], 1'b0};
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (last_bit) begin
          kappa_r <= neg_r ? -$signed(qx) : $signed(qx);
        end
      end
      default: begin
        cnt_r <= '0;
      end
    endcase
  end

  always_comb begin
    res.done  = done_r;
    res.kappa = kappa_r;
  end

endmodule

`default_nettype wire

>>> rtl/sliding_window_cohen_kappa_unit.sv
// Top level of the sliding-window Cohen's kappa unit: label pair window memory,
// update sequencer and output register. Depends on kcu_pkg, kcu_cmem, kcu_kappa.
//
// Input beats carry one (actual, predicted) label pair, or a clear request in
// in_tuser. Every input beat yields exactly one output beat with kappa in
// signed Q1.16, a window-full flag, a label error flag and the agreement count.
// One item is in work at a time. A clear, or a label error with the window not
// full, goes straight to the output register. A pair that leaves the window not
// full only updates the counts. A label error with the window full recomputes
// kappa; a pair that fills the window or enters a full one updates the counts
// and then recomputes kappa. The division is skipped when kappa saturates.
// A full-window pair needs four read-modify-write passes on the count memory
// (one port) and a bit-serial division.
// The result waits in the output register; the next input beat is taken while
// it waits, and the following result holds inside until the receiver takes
// the previous one. Reset, a clear beat, or any configuration write empties
// the window and all counts; window memory needs no clearing pass.
// Make configuration writes only while no item is in work; the block does not enforce it.
`default_nettype none

module sliding_window_cohen_kappa_unit
  import kcu_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  [IN_DATA_W-1:0]  in_tdata,   // true_cls[3:0], pred_cls[7:4]
  input  wire  [IN_USER_W-1:0]  in_tuser,   // clear_window[0]
  output logic                  out_tvalid,
  input  wire                   out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // kappa_value[17:0], agreements_in_window[28:18]
  output logic [OUT_USER_W-1:0] out_tuser,  // kappa_valid[0], label_error[1]
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_addr,
  input  wire  [CFG_W-1:0]      cfg_wdata
);

  localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CA_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;

  kcu_state_t        state_r, state_nxt;
  kcu_step_t         step_r;
  logic [CNT_W-1:0]  ws_r, fill_r, agree_r, w_eff, fill_nxt;
  logic [CC_W-1:0]   cc_r, cc_eff;
  logic [AW-1:0]     wp_r;
  logic [SQ_W-1:0]   s_r;
  logic [LBL_W-1:0]  lbl_a_r, lbl_p_r;
  logic [CA_W-1:0]   oa_r, op_r, cm_addr;
  logic [PAIR_W-1:0] win_mem [WINDOW_DEPTH];
  logic [PAIR_W-1:0] win_q_r;
  logic              res_err_r, res_valid_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  logic [LBL_W-1:0]  in_a, in_p, ev_a, ev_p;
  logic              in_clr, in_fire, lbl_err, full, out_load, ev_agree;
  logic [CNT_W-1:0]  c_act, c_prd;
  logic [CWORD_W-1:0] cm_rd_data, cm_wr_data;
  logic [SQ_W-1:0]   s_nxt;
  kcu_cmem_ctl_t     cm_ctl;
  kcu_kreq_t         kreq;
  kcu_kres_t         kres;

  assign in_a   = in_tdata[LBL_W-1:0];
  assign in_p   = in_tdata[2*LBL_W-1:LBL_W];
  assign in_clr = in_tuser[0];
  assign ev_a   = win_q_r[LBL_W-1:0];
  assign ev_p   = win_q_r[2*LBL_W-1:LBL_W];

  always_comb begin
    if (ws_r == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(ws_r) > WINDOW_DEPTH) begin
      w_eff = CNT_W'(WINDOW_DEPTH);
    end else begin
      w_eff = ws_r;
    end
    cc_eff   = (32'(cc_r) > MAX_CLASSES) ? CC_W'(MAX_CLASSES) : cc_r;
    lbl_err  = ({1'b0, in_a} >= cc_eff) || ({1'b0, in_p} >= cc_eff);
    full     = fill_r >= w_eff;
    fill_nxt = full ? fill_r : fill_r + 1'b1;
    ev_agree = full && (ev_a == ev_p);
    in_fire  = in_tvalid && in_tready;
    out_load = (state_r == S_OUT) && (!out_tvalid_r || out_tready);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_clr) begin
            state_nxt = S_OUT;
          end else if (lbl_err) begin
            state_nxt = full ? S_KSTART : S_OUT;
          end else begin
            state_nxt = S_WIN;
          end
        end
      end
      S_WIN:    state_nxt = S_RD;
      S_RD:     state_nxt = S_MOD;
      S_MOD: begin
        if (step_r == ST_IN_PRED) begin
          state_nxt = res_valid_r ? S_KSTART : S_OUT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_KSTART: state_nxt = S_KWAIT;
      S_KWAIT:  if (kres.done) state_nxt = S_OUT;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready    = state_r == S_IDLE;
    cm_ctl.rd_en = state_r == S_RD;
    cm_ctl.wr_en = state_r == S_MOD;
    cm_ctl.clr   = cfg_we || (in_fire && in_clr);
    kreq.start   = state_r == S_KSTART;
    kreq.n       = w_eff;
    kreq.agree   = agree_r;
    kreq.s       = s_r;
  end

  always_comb begin
    case (step_r)
      ST_EV_ACT:  cm_addr = oa_r;
      ST_EV_PRED: cm_addr = op_r;
      ST_IN_ACT:  cm_addr = CA_W'(lbl_a_r);
      ST_IN_PRED: cm_addr = CA_W'(lbl_p_r);
      default:    cm_addr = oa_r;
    endcase
  end

  // count update: one class word per pass
  always_comb begin
    c_act      = cm_rd_data[CWORD_W-1:CNT_W];
    c_prd      = cm_rd_data[CNT_W-1:0];
    cm_wr_data = cm_rd_data;
    s_nxt      = s_r;
    case (step_r)
      ST_EV_ACT: begin
        cm_wr_data = {c_act - 1'b1, c_prd};
        s_nxt      = s_r - SQ_W'(c_prd);
      end
      ST_EV_PRED: begin
        cm_wr_data = {c_act, c_prd - 1'b1};
        s_nxt      = s_r - SQ_W'(c_act);
      end
      ST_IN_ACT: begin
        cm_wr_data = {c_act + 1'b1, c_prd};
        s_nxt      = s_r + SQ_W'(c_prd);
      end
      ST_IN_PRED: begin
        cm_wr_data = {c_act, c_prd + 1'b1};
        s_nxt      = s_r + SQ_W'(c_act);
      end
      default: begin
        cm_wr_data = cm_rd_data;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      win_q_r <= win_mem[wp_r];
    end
    if (state_r == S_WIN) begin
      win_mem[wp_r] <= {lbl_p_r, lbl_a_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      step_r       <= ST_EV_ACT;
      ws_r         <= WS_RESET;
      cc_r         <= CC_RESET;
      wp_r         <= '0;
      fill_r       <= '0;
      agree_r      <= '0;
      s_r          <= '0;
      res_err_r    <= 1'b0;
      res_valid_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_WINDOW_SIZE: ws_r <= cfg_wdata;
          REG_CLASS_COUNT: cc_r <= cfg_wdata[CC_W-1:0];
          default: ;
        endcase
        wp_r    <= '0;
        fill_r  <= '0;
        agree_r <= '0;
        s_r     <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_err_r   <= !in_clr && lbl_err;
            res_valid_r <= !in_clr && lbl_err && full;
            if (in_clr) begin
              wp_r    <= '0;
              fill_r  <= '0;
              agree_r <= '0;
              s_r     <= '0;
            end
          end
        end
        S_WIN: begin
          fill_r      <= fill_nxt;
          res_valid_r <= fill_nxt >= w_eff;
          agree_r     <= agree_r - CNT_W'(ev_agree) + CNT_W'(lbl_a_r == lbl_p_r);
          wp_r        <= (32'(wp_r) + 1 >= 32'(w_eff)) ? '0 : AW'(32'(wp_r) + 1);
          step_r      <= full ? ST_EV_ACT : ST_IN_ACT;
        end
        S_MOD: begin
          s_r <= s_nxt;
          case (step_r)
            ST_EV_ACT:  step_r <= ST_EV_PRED;
            ST_EV_PRED: step_r <= ST_IN_ACT;
            ST_IN_ACT:  step_r <= ST_IN_PRED;
            default:    step_r <= ST_EV_ACT;
          endcase
        end
        default: ;
      endcase
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      lbl_a_r <= in_a;
      lbl_p_r <= in_p;
    end
    if (state_r == S_WIN) begin
      oa_r <= CA_W'(ev_a);
      op_r <= CA_W'(ev_p);
    end
    if (out_load) begin
      out_data_r <= {{(OUT_DATA_W - CNT_W - KAP_W){1'b0}}, agree_r,
                     res_valid_r ? kres.kappa : {KAP_W{1'b0}}};
      out_user_r <= {res_err_r, res_valid_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  kcu_cmem #(
    .NUM_CLASSES (MAX_CLASSES)
  ) u_cmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (cm_ctl),
    .rd_addr (cm_addr),
    .wr_addr (cm_addr),
    .wr_data (cm_wr_data),
    .rd_data (cm_rd_data)
  );

  kcu_kappa u_kappa (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (kreq),
    .res   (kres)
  );

`ifndef NO_ASSERTIONS
  a_agree_le_fill : assert property (@(posedge clk) disable iff (!rst_n)
    agree_r <= fill_r)
    else $error("agreement count exceeds window fill");

  a_fill_le_window : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= w_eff)
    else $error("window fill exceeds window length");

  a_ptr_in_window : assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) < 32'(w_eff))
    else $error("write pointer outside window");

  a_kappa_done_wait : assert property (@(posedge clk) disable iff (!rst_n)
    kres.done |-> state_r == S_KWAIT)
    else $error("kappa result outside wait state");
`endif

endmodule

`default_nettype wire

>>> dv/kappa_stream_checker.sv
// Watches the label-pair, result and register ports of the sliding-window kappa unit,
// predicts every result beat and compares it field by field. Depends on kcu_pkg.
`default_nettype none

module kappa_stream_checker
  import kcu_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  input  wire                   in_tready,
  input  wire  [IN_DATA_W-1:0]  in_tdata,   // true_cls[3:0], pred_cls[7:4]
  input  wire  [IN_USER_W-1:0]  in_tuser,   // clear_window[0]
  input  wire                   out_tvalid,
  input  wire                   out_tready,
  input  wire  [OUT_DATA_W-1:0] out_tdata,  // kappa_value[17:0], agreements_in_window[28:18]
  input  wire  [OUT_USER_W-1:0] out_tuser,  // kappa_valid[0], label_error[1]
  input  wire                   cfg_we,
  input  wire  [CFG_IDX_W-1:0]  cfg_addr,
  input  wire  [CFG_W-1:0]      cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           beats_checked,
  output int unsigned           results_pending
);

  typedef struct {
    logic signed [KAP_W-1:0] kappa;
    logic                    full;
    logic                    bad_label;
    logic [CNT_W-1:0]        agree;
  } kappa_beat_t;

  localparam int HAW = $clog2(WINDOW_DEPTH);

  logic [CNT_W-1:0] window_reg;
  logic [CC_W-1:0]  classes_reg;
  logic [LBL_W-1:0] hist_act [WINDOW_DEPTH];
  logic [LBL_W-1:0] hist_prd [WINDOW_DEPTH];
  int unsigned      head;
  int unsigned      filled;
  int unsigned      agree_cnt;
  int unsigned      act_cnt [MAX_CLASSES];
  int unsigned      prd_cnt [MAX_CLASSES];
  longint unsigned  chance_sum;
  kappa_beat_t      kappa_expected_q [$];
  int unsigned      fail_count;
  int unsigned      match_count;

  assign mismatches    = fail_count;
  assign beats_checked = match_count;

  function automatic void empty_window();
    head       = 0;
    filled     = 0;
    agree_cnt  = 0;
    chance_sum = 0;
    act_cnt    = '{default: 0};
    prd_cnt    = '{default: 0};
  endfunction

  function automatic int unsigned window_len();
    if (window_reg == 0) return 1;
    if (window_reg > WINDOW_DEPTH) return WINDOW_DEPTH;
    return int'(window_reg);
  endfunction

  function automatic int unsigned class_limit();
    return (classes_reg > MAX_CLASSES) ? MAX_CLASSES : int'(classes_reg);
  endfunction

  function automatic logic signed [KAP_W-1:0] kappa_q16(input int unsigned n);
    longint unsigned nn;
    longint unsigned pos;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned q;
    longint          k;
    logic            neg;
    nn  = longint'(n) * n;
    pos = longint'(n) * agree_cnt;
    if (chance_sum >= nn) return Q_ONE;
    den = nn - chance_sum;
    neg = pos < chance_sum;
    mag = neg ? chance_sum - pos : pos - chance_sum;
    q   = (mag * 65536 + den / 2) / den;
    if (q > 65536) q = 65536;
    k = neg ? -longint'(q) : longint'(q);
    return k[KAP_W-1:0];
  endfunction

  function automatic kappa_beat_t predict_kappa_beat(input logic [LBL_W-1:0] a,
                                                     input logic [LBL_W-1:0] p,
                                                     input logic clr);
    kappa_beat_t      r;
    int unsigned      w;
    int unsigned      cc;
    int unsigned      slot;
    logic [LBL_W-1:0] oa;
    logic [LBL_W-1:0] op;
    w           = window_len();
    cc          = class_limit();
    r.kappa     = '0;
    r.full      = 1'b0;
    r.bad_label = 1'b0;
    if (clr) begin
      empty_window();
    end else if (a >= cc || p >= cc) begin
      r.bad_label = 1'b1;
    end else begin
      slot = head % w;
      if (filled >= w) begin
        oa          = hist_act[slot[HAW-1:0]];
        op          = hist_prd[slot[HAW-1:0]];
        act_cnt[oa] = act_cnt[oa] - 1;
        chance_sum  = chance_sum - prd_cnt[oa];
        prd_cnt[op] = prd_cnt[op] - 1;
        chance_sum  = chance_sum - act_cnt[op];
        if (oa == op) agree_cnt = agree_cnt - 1;
      end else begin
        filled = filled + 1;
      end
      hist_act[slot[HAW-1:0]] = a;
      hist_prd[slot[HAW-1:0]] = p;
      act_cnt[a]     = act_cnt[a] + 1;
      chance_sum     = chance_sum + prd_cnt[a];
      prd_cnt[p]     = prd_cnt[p] + 1;
      chance_sum     = chance_sum + act_cnt[p];
      if (a == p) agree_cnt = agree_cnt + 1;
      head = (slot + 1 >= w) ? 0 : slot + 1;
    end
    if (!clr && filled >= w) begin
      r.full  = 1'b1;
      r.kappa = kappa_q16(w);
    end
    r.agree = agree_cnt[CNT_W-1:0];
    return r;
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endfunction

  initial begin
    fail_count  = 0;
    match_count = 0;
    window_reg  = WS_RESET;
    classes_reg = CC_RESET;
    empty_window();
  end

  always @(posedge clk) begin
    kappa_beat_t exp_b;
    kappa_beat_t got_b;
    if (!rst_n) begin
      window_reg  = WS_RESET;
      classes_reg = CC_RESET;
      empty_window();
      kappa_expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_WINDOW_SIZE) window_reg = cfg_wdata[CNT_W-1:0];
        else if (cfg_addr == REG_CLASS_COUNT) classes_reg = cfg_wdata[CC_W-1:0];
        empty_window();
      end
      if (out_tvalid && out_tready) begin
        got_b.kappa     = out_tdata[KAP_W-1:0];
        got_b.agree     = out_tdata[KAP_W+CNT_W-1:KAP_W];
        got_b.full      = out_tuser[0];
        got_b.bad_label = out_tuser[1];
        if (kappa_expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with nothing expected, expected none, actual kappa %0d",
                   $time, got_b.kappa);
        end else begin
          exp_b = kappa_expected_q[0];
          kappa_expected_q.delete(0);
          check_field("kappa_value", int'(exp_b.kappa), int'(got_b.kappa));
          check_field("kappa_valid", int'(exp_b.full), int'(got_b.full));
          check_field("label_error", int'(exp_b.bad_label), int'(got_b.bad_label));
          check_field("agreements_in_window", int'(exp_b.agree), int'(got_b.agree));
          match_count++;
        end
      end
      if (in_tvalid && in_tready)
        kappa_expected_q.insert(kappa_expected_q.size(),
                                predict_kappa_beat(in_tdata[LBL_W-1:0],
                                                   in_tdata[2*LBL_W-1:LBL_W],
                                                   in_tuser[0]));
    end
    results_pending <= kappa_expected_q.size();
  end

endmodule

`default_nettype wire

>>> dv/sliding_window_cohen_kappa_unit_tb.sv
// Stimulus and verdict for the sliding-window Cohen's kappa unit: directed label pairs,
// then random phases over window sizes, class counts and idle patterns.
// Depends on kcu_pkg, sliding_window_cohen_kappa_unit and kappa_stream_checker.
`default_nettype none

module sliding_window_cohen_kappa_unit_tb;
  import kcu_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [IN_USER_W-1:0]  in_tuser   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_W-1:0]      cfg_wdata  = '0;
  wire                   in_tready;
  wire                   out_tvalid;
  wire  [OUT_DATA_W-1:0] out_tdata;
  wire  [OUT_USER_W-1:0] out_tuser;

  int unsigned mismatches;
  int unsigned beats_checked;
  int unsigned results_pending;
  int unsigned beats_sent = 0;
  int unsigned gap_pct    = 0;
  int unsigned stall_pct  = 0;

  sliding_window_cohen_kappa_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  kappa_stream_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatches     (mismatches),
    .beats_checked  (beats_checked),
    .results_pending(results_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic push_pair(input logic [LBL_W-1:0] a, input logic [LBL_W-1:0] p,
                           input logic clr);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {p, a};
    in_tuser  <= clr;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
  endtask

  task automatic set_window_and_classes(input int unsigned ws, input int unsigned cc);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_WINDOW_SIZE;
    cfg_wdata <= ws[CFG_W-1:0];
    @(posedge clk);
    cfg_addr  <= REG_CLASS_COUNT;
    cfg_wdata <= cc[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned ws, input int unsigned cc, input int unsigned n,
                           input int unsigned gap, input int unsigned stall,
                           input int unsigned clear_pct, input int unsigned error_pct);
    int unsigned      lim;
    int unsigned      r;
    logic [LBL_W-1:0] a;
    logic [LBL_W-1:0] p;
    logic             clr;
    set_window_and_classes(ws, cc);
    gap_pct   = gap;
    stall_pct <= stall;
    lim = (cc > MAX_CLASSES) ? MAX_CLASSES : cc;
    for (int i = 0; i < n; i++) begin
      r   = $urandom_range(99);
      clr = 1'b0;
      if (r < clear_pct) begin
        clr = 1'b1;
        a   = LBL_W'($urandom_range(15));
        p   = LBL_W'($urandom_range(15));
      end else if (lim == 0) begin
        a = LBL_W'($urandom_range(15));
        p = LBL_W'($urandom_range(15));
      end else if (r < clear_pct + error_pct && lim < MAX_CLASSES) begin
        a = LBL_W'($urandom_range(15));
        p = LBL_W'($urandom_range(lim, 15));
        if ($urandom_range(1)) {a, p} = {p, a};
      end else begin
        a = LBL_W'($urandom_range(lim - 1));
        p = ($urandom_range(99) < 60) ? a : LBL_W'($urandom_range(lim - 1));
      end
      push_pair(a, p, clr);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    push_pair(4'd0, 4'd0, 1'b0);
    push_pair(4'd1, 4'd1, 1'b0);
    push_pair(4'd2, 4'd0, 1'b0);
    push_pair(4'd0, 4'd1, 1'b0);
    push_pair(4'd7, 4'd9, 1'b1);

    set_window_and_classes(1, 16);
    push_pair(4'd0, 4'd0, 1'b0);
    push_pair(4'd15, 4'd15, 1'b0);
    push_pair(4'd15, 4'd0, 1'b0);
    push_pair(4'd0, 4'd15, 1'b0);
    push_pair(4'd5, 4'd5, 1'b0);
    push_pair(4'd15, 4'd15, 1'b1);

    set_window_and_classes(2, 2);
    push_pair(4'd0, 4'd1, 1'b0);
    push_pair(4'd1, 4'd0, 1'b0);
    push_pair(4'd1, 4'd1, 1'b0);
    push_pair(4'd0, 4'd0, 1'b0);
    push_pair(4'd3, 4'd0, 1'b0);

    set_window_and_classes(0, 0);
    push_pair(4'd0, 4'd0, 1'b0);
    push_pair(4'd15, 4'd15, 1'b0);

    set_window_and_classes(0, 1);
    push_pair(4'd0, 4'd0, 1'b0);
    push_pair(4'd0, 4'd1, 1'b0);
    push_pair(4'd1, 4'd0, 1'b0);

    set_window_and_classes(2047, 31);
    push_pair(4'd15, 4'd14, 1'b0);
    push_pair(4'd0, 4'd0, 1'b0);

    run_phase(1, 2, 40, 0, 0, 3, 6);
    run_phase(7, 3, 60, 52, 0, 3, 6);
    run_phase(16, 16, 60, 0, 52, 3, 6);
    run_phase($urandom_range(3, 40), $urandom_range(2, 16), 60, 29, 29, 3, 6);
    run_phase(250, 16, 280, 29, 29, 0, 2);
    run_phase(2047, 31, 20, 52, 0, 3, 6);
    run_phase(0, 17, 30, 0, 52, 3, 6);
    run_phase($urandom_range(2, 64), $urandom_range(2, 16), 40, 0, 0, 3, 6);

    drain_results();
    repeat (40) @(posedge clk);
    $display("Sent %0d label beats, checked %0d result beats across window sizes 0 to 2047,",
             beats_sent, beats_checked);
    $display("class counts 0 to 31, clears, label errors and four idle patterns.");
    if (mismatches == 0) begin
      $display("sliding_window_cohen_kappa_unit test passed");
    end else begin
      $display("sliding_window_cohen_kappa_unit test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sliding_window_cohen_kappa_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
